[rtl/cc20_pkg.sv]
// ============================================================================
// cc20_pkg
// Shared types, constants and helper functions for the ChaCha20 keystream
// block pipeline.
// ============================================================================
package cc20_pkg;

    // Round count and the pipeline depth that follows from it.
    // Each double round takes four stages:
    // column round first half, column round second half,
    // diagonal round first half, diagonal round second half.
    localparam int DOUBLE_ROUNDS = 10;
    localparam int NUM_STAGES    = 4 * DOUBLE_ROUNDS;
    // Delay from an accepted command to its result: the round stages plus the feed-forward stage.
    localparam int LATENCY       = NUM_STAGES + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 8'd3;

    // "expand 32-byte k", word 0 in the low slot
    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    // Sixteen 32-bit state words, word 0 in the low slot
    typedef logic [15:0][31:0] t_words;

    // Four 64-bit key words, key_word_0 in the low slot
    typedef logic [3:0][63:0] t_key;

    // Input transaction payload
    typedef struct packed {
        logic [31:0] block_counter;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
    } t_in_item;

    // Result transaction payload
    typedef struct packed {
        logic [63:0] keystream_0;
        logic [63:0] keystream_1;
        logic [63:0] keystream_2;
        logic [63:0] keystream_3;
        logic [63:0] keystream_4;
        logic [63:0] keystream_5;
        logic [63:0] keystream_6;
        logic [63:0] keystream_7;
    } t_out_item;

    // Per-stage selection: which half round and which half of the quarter round
    typedef struct packed {
        logic diag;
        logic second;
    } t_stage_cfg;

    // Build the initial 16-word state from key and transaction fields
    function automatic t_words init_state(t_key key, t_in_item item);
        t_words w;
        for (int k = 0; k < 4; k++) begin
            w[k]         = SIGMA[k];
            w[4 + 2 * k] = key[k][31:0];
            w[5 + 2 * k] = key[k][63:32];
        end
        w[12] = item.block_counter;
        w[13] = item.nonce_low[31:0];
        w[14] = item.nonce_low[63:32];
        w[15] = item.nonce_high;
        return w;
    endfunction

    // State word index of one lane member; role 0..3 picks a, b, c, d
    function automatic logic [3:0] lane_idx(logic diag, logic [1:0] q, logic [1:0] role);
        logic [1:0] col;
        col = diag ? 2'(q + role) : q;
        return {role, col};
    endfunction

endpackage

[rtl/cc20_key_regs.sv]
// ============================================================================
// cc20_key_regs
// Key register file: four 64-bit words written through the configuration
// channel. Writes to unknown indexes are dropped.
// ============================================================================
module cc20_key_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    output cc20_pkg::t_key                 o_key
);

    cc20_pkg::t_key r_key;
    cc20_pkg::t_key n_key;

    // Always ready: a write goes straight into the key registers
    assign o_cfg_ready = 1'b1;

    // Next key value
    always_comb begin
        n_key = r_key;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cc20_pkg::CFG_KEY_WORD_0: n_key[0] = i_cfg_data;
                cc20_pkg::CFG_KEY_WORD_1: n_key[1] = i_cfg_data;
                cc20_pkg::CFG_KEY_WORD_2: n_key[2] = i_cfg_data;
                cc20_pkg::CFG_KEY_WORD_3: n_key[3] = i_cfg_data;
                default: n_key = r_key;
            endcase
        end
    end

    // Key registers, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

endmodule

[rtl/cc20_round_stage.sv]
// ============================================================================
// cc20_round_stage
// One pipeline stage: half of each of the four quarter rounds of a column or
// diagonal round (two add-xor-rotate steps per lane), then a register.
// ============================================================================
module cc20_round_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cc20_pkg::t_stage_cfg i_cfg,
    input  logic                 i_valid,
    input  cc20_pkg::t_words     i_words,
    input  cc20_pkg::t_in_item   i_item,
    output logic                 o_valid,
    output cc20_pkg::t_words     o_words,
    output cc20_pkg::t_in_item   o_item
);

    logic               r_valid;
    cc20_pkg::t_words   r_words;
    cc20_pkg::t_in_item r_item;
    cc20_pkg::t_words   n_words;

    // Four independent lanes; i_cfg is fixed per instance
    always_comb begin
        cc20_pkg::t_words w;
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] a, b, c, d, x;
        w = i_words;
        for (int q = 0; q < 4; q++) begin
            ia = cc20_pkg::lane_idx(i_cfg.diag, 2'(q), 2'd0);
            ib = cc20_pkg::lane_idx(i_cfg.diag, 2'(q), 2'd1);
            ic = cc20_pkg::lane_idx(i_cfg.diag, 2'(q), 2'd2);
            id = cc20_pkg::lane_idx(i_cfg.diag, 2'(q), 2'd3);
            a = w[ia];
            b = w[ib];
            c = w[ic];
            d = w[id];
            // a += b; d = (d ^ a) <<< 16 or 8
            a = a + b;
            x = d ^ a;
            d = i_cfg.second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
            // c += d; b = (b ^ c) <<< 12 or 7
            c = c + d;
            x = b ^ c;
            b = i_cfg.second ? {x[24:0], x[31:25]} : {x[19:0], x[31:20]};
            w[ia] = a;
            w[ib] = b;
            w[ic] = c;
            w[id] = d;
        end
        n_words = w;
    end

    // Valid bit, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        r_item  <= i_item;
    end

    assign o_valid = r_valid;
    assign o_words = r_words;
    assign o_item  = r_item;

endmodule

[rtl/cc20_feedfwd.sv]
// ============================================================================
// cc20_feedfwd
// Final stage: adds the initial state back word by word and registers the
// 64-byte keystream with its strobe.
// ============================================================================
module cc20_feedfwd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cc20_pkg::t_words    i_words,
    input  cc20_pkg::t_in_item  i_item,
    input  cc20_pkg::t_key      i_key,
    output logic                o_strobe,
    output cc20_pkg::t_out_item o_result
);

    logic                r_strobe;
    cc20_pkg::t_out_item r_result;
    cc20_pkg::t_out_item n_result;

    // Feed-forward add and little-endian packing
    always_comb begin
        cc20_pkg::t_words init;
        cc20_pkg::t_words sum;
        init = cc20_pkg::init_state(i_key, i_item);
        for (int k = 0; k < 16; k++) begin
            sum[k] = i_words[k] + init[k];
        end
        n_result.keystream_0 = {sum[1],  sum[0]};
        n_result.keystream_1 = {sum[3],  sum[2]};
        n_result.keystream_2 = {sum[5],  sum[4]};
        n_result.keystream_3 = {sum[7],  sum[6]};
        n_result.keystream_4 = {sum[9],  sum[8]};
        n_result.keystream_5 = {sum[11], sum[10]};
        n_result.keystream_6 = {sum[13], sum[12]};
        n_result.keystream_7 = {sum[15], sum[14]};
    end

    // Strobe, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[rtl/chacha20_keystream_block_top.sv]
// ============================================================================
// chacha20_keystream_block_top
// ChaCha20 block function (96-bit nonce form) as a fully unrolled pipeline:
// one keystream block per clock.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ---------------------------
//  command   in         start && !busy            i_item (counter, nonce)
//  result    out        o_strobe, one cycle       o_result (64 bytes)
//  config    in         i_cfg_valid && ready      i_cfg_index, i_cfg_data
//
//  A new transaction is taken every cycle; busy is always low.
//  Pipeline: one register stage per half of each column or diagonal round,
//  followed by the feed-forward stage.
//  Synchronous active-low reset clears the key and all valid bits.
//  The receiver cannot stall; results leave in accept order.
//  Keys must be stable while transactions are in flight.
//
module chacha20_keystream_block_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cc20_pkg::t_in_item             i_item,
    output logic                           o_strobe,
    output cc20_pkg::t_out_item            o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);

    cc20_pkg::t_key     key;
    logic               accept;
    logic               valid_chain [0:cc20_pkg::NUM_STAGES];
    cc20_pkg::t_words   words_chain [0:cc20_pkg::NUM_STAGES];
    cc20_pkg::t_in_item item_chain  [0:cc20_pkg::NUM_STAGES];

    // Pipeline never blocks
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Key registers
    cc20_key_regs u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key)
    );

    // Pipeline entry: initial state built from key and command fields
    assign valid_chain[0] = accept;
    assign words_chain[0] = cc20_pkg::init_state(key, i_item);
    assign item_chain[0]  = i_item;

    // Round stages: col/first, col/second, diag/first, diag/second, repeated
    for (genvar s = 0; s < cc20_pkg::NUM_STAGES; s++) begin : g_stage
        localparam cc20_pkg::t_stage_cfg STAGE_CFG = '{
            diag:   1'((s / 2) % 2),
            second: 1'(s % 2)
        };
        cc20_round_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (STAGE_CFG),
            .i_valid (valid_chain[s]),
            .i_words (words_chain[s]),
            .i_item  (item_chain[s]),
            .o_valid (valid_chain[s + 1]),
            .o_words (words_chain[s + 1]),
            .o_item  (item_chain[s + 1])
        );
    end

    // Feed-forward add and output register
    cc20_feedfwd u_feedfwd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (valid_chain[cc20_pkg::NUM_STAGES]),
        .i_words  (words_chain[cc20_pkg::NUM_STAGES]),
        .i_item   (item_chain[cc20_pkg::NUM_STAGES]),
        .i_key    (key),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Every accepted command yields a result strobe
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(cc20_pkg::LATENCY) o_strobe)
        else $error("result strobe missing after accepted command");

    // A strobe only follows a valid item leaving the last round stage
    a_strobe_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(valid_chain[cc20_pkg::NUM_STAGES]))
        else $error("result strobe without a finished item");

    // No result in the cycle after reset
    a_reset_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("result strobe right after reset");

endmodule

[test/chacha20_keystream_block_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// chacha20_keystream_block_top_tb
// Self-checking bench for the ChaCha20 keystream pipeline. An internal model
// of the block function predicts each 64-byte block at the accepting edge;
// a monitor compares every strobed result, lane by lane, in order. Directed
// blocks cover key and field extremes and the RFC sample inputs. Random
// traffic follows, under several key settings and sender idle rates.
// ============================================================================
module chacha20_keystream_block_top_tb;

    typedef logic [7:0][63:0] t_lanes;
    typedef logic [cc20_pkg::CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes past the key words; writes there must be dropped
    localparam t_cfg_idx CFG_IDX_FIRST_UNUSED = cc20_pkg::CFG_KEY_WORD_3 + 1'b1;
    localparam t_cfg_idx CFG_IDX_LAST         = '1;
    localparam int RANDOM_PHASE_BLOCKS = 300;
    localparam int MAX_REPORTS         = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    cc20_pkg::t_in_item  i_item;
    logic                o_strobe;
    cc20_pkg::t_out_item o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_index;
    logic [63:0]         i_cfg_data;

    // Model key copy and blocks still owed by the pipeline
    logic [63:0]         key_reg [4];
    cc20_pkg::t_out_item keystream_q [$];
    int                  fail_count = 0;

    chacha20_keystream_block_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("chacha20_keystream_block_top regression: fail");
        $finish;
    end

    function automatic logic [31:0] rotl32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // ChaCha20 block function on the current key
    function automatic cc20_pkg::t_out_item predict_keystream(cc20_pkg::t_in_item item);
        logic [31:0] init_w [16];
        logic [31:0] w [16];
        logic [31:0] lo;
        logic [31:0] hi;
        t_lanes      lanes;
        int          a, b, c, d, col;
        init_w[0] = 32'h61707865;
        init_w[1] = 32'h3320646e;
        init_w[2] = 32'h79622d32;
        init_w[3] = 32'h6b206574;
        for (int k = 0; k < 4; k++) begin
            init_w[4 + 2 * k] = key_reg[k][31:0];
            init_w[5 + 2 * k] = key_reg[k][63:32];
        end
        init_w[12] = item.block_counter;
        init_w[13] = item.nonce_low[31:0];
        init_w[14] = item.nonce_low[63:32];
        init_w[15] = item.nonce_high;
        w = init_w;
        for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
            for (int q = 0; q < 8; q++) begin
                // columns first, then diagonals
                col = q % 4;
                a = col;
                if (q < 4) begin
                    b = 4 + col;
                    c = 8 + col;
                    d = 12 + col;
                end else begin
                    b = 4 + (col + 1) % 4;
                    c = 8 + (col + 2) % 4;
                    d = 12 + (col + 3) % 4;
                end
                w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
                w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
                w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
                w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
            end
        end
        // feed-forward; lane 0 sits in the top slot of the struct
        for (int k = 0; k < 8; k++) begin
            lo = w[2 * k] + init_w[2 * k];
            hi = w[2 * k + 1] + init_w[2 * k + 1];
            lanes[7 - k] = {hi, lo};
        end
        return cc20_pkg::t_out_item'(lanes);
    endfunction

    function automatic cc20_pkg::t_in_item make_item(logic [31:0] ctr, logic [63:0] nlo,
                                                     logic [31:0] nhi);
        cc20_pkg::t_in_item item;
        item.block_counter = ctr;
        item.nonce_low     = nlo;
        item.nonce_high    = nhi;
        return item;
    endfunction

    // Random word, leaning on all-zero and all-one values
    function automatic logic [31:0] pick32();
        unique case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick64();
        return {pick32(), pick32()};
    endfunction

    // Result monitor: one block per strobe, checked against the oldest prediction
    always @(posedge i_clk) begin : check_keystream
        t_lanes want;
        t_lanes got;
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            got = t_lanes'(o_result);
            if (keystream_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected keystream block, actual %h", $time, got);
            end else begin
                want = t_lanes'(keystream_q.pop_front());
                for (int j = 0; j < 8; j++) begin
                    if (got[7 - j] !== want[7 - j]) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: keystream_%0d expected %h actual %h",
                                     $time, j, want[7 - j], got[7 - j]);
                    end
                end
            end
        end
    end

    // One command transaction, then an optional idle gap of start low
    task automatic send_block(input cc20_pkg::t_in_item item, input int idle_pct);
        int gap;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        keystream_q.push_back(predict_keystream(item));
        // each following cycle stays idle with probability idle_pct percent
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and let the pipeline empty out
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (keystream_q.size() != 0) @(posedge i_clk);
        repeat (cc20_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    // One config transaction; valid is left high for a following write
    task automatic write_cfg(input t_cfg_idx idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        unique case (idx)
            cc20_pkg::CFG_KEY_WORD_0: key_reg[0] = data;
            cc20_pkg::CFG_KEY_WORD_1: key_reg[1] = data;
            cc20_pkg::CFG_KEY_WORD_2: key_reg[2] = data;
            cc20_pkg::CFG_KEY_WORD_3: key_reg[3] = data;
            default: ;
        endcase
    endtask

    // Full key load plus a write to an unused index; pipeline must be idle
    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_cfg(cc20_pkg::CFG_KEY_WORD_0, k0);
        write_cfg(cc20_pkg::CFG_KEY_WORD_1, k1);
        write_cfg(cc20_pkg::CFG_KEY_WORD_2, k2);
        write_cfg(cc20_pkg::CFG_KEY_WORD_3, k3);
        write_cfg(t_cfg_idx'($urandom_range(CFG_IDX_FIRST_UNUSED, CFG_IDX_LAST)),
                  {$urandom, $urandom});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Key still at its reset value of zero
    task automatic test_reset_key();
        send_block(make_item('0, '0, '0), 0);
        send_block(make_item('1, '1, '1), 0);
        send_block(make_item(32'hffff_ffff, '0, '0), 0);
        wait_drained();
    endtask

    // All-ones and checkerboard keys
    task automatic test_extreme_keys();
        load_key('1, '1, '1, '1);
        send_block(make_item('0, '0, '0), 0);
        send_block(make_item('1, '1, '1), 0);
        send_block(make_item('0, '1, '1), 0);
        wait_drained();
        load_key({16{4'h5}}, {16{4'ha}}, {16{4'h5}}, {16{4'ha}});
        send_block(make_item({8{4'h5}}, {16{4'ha}}, {8{4'h5}}), 0);
        send_block(make_item({8{4'ha}}, {16{4'h5}}, {8{4'ha}}), 0);
        wait_drained();
    endtask

    // Sample key 00..1f with the RFC block and cipher nonces
    task automatic test_rfc_vectors();
        load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                 64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
        send_block(make_item(32'd1, 64'h4a000000_09000000, '0), 0);
        send_block(make_item(32'd1, 64'h4a000000_00000000, '0), 0);
        send_block(make_item(32'hffff_ffff, 64'h4a000000_00000000, '0), 0);
        wait_drained();
    endtask

    // Writes beyond the key registers leave the key alone
    task automatic test_ignored_index();
        write_cfg(CFG_IDX_FIRST_UNUSED, '1);
        write_cfg(CFG_IDX_LAST, '1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        send_block(make_item(32'd7, 64'h0123_4567_89ab_cdef, 32'hdead_beef), 0);
        send_block(make_item('0, '0, '0), 0);
        wait_drained();
    endtask

    // Random blocks under fresh keys and varying sender idle rates
    task automatic test_random_traffic();
        int idle_pct [6] = '{0, 59, 0, 20, 59, 20};
        for (int p = 0; p < 6; p++) begin
            if (p == 0)
                load_key({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
            else
                load_key(pick64(), pick64(), pick64(), pick64());
            for (int n = 0; n < RANDOM_PHASE_BLOCKS; n++) begin
                send_block(make_item(pick32(), pick64(), pick32()), idle_pct[p]);
                // hold off until every pending block is back
                if (n == RANDOM_PHASE_BLOCKS / 2 || $urandom_range(0, 199) == 0)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int k = 0; k < 4; k++) key_reg[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_key();
        test_extreme_keys();
        test_rfc_vectors();
        test_ignored_index();
        test_random_traffic();

        if (fail_count == 0) begin
            $display("chacha20_keystream_block_top regression: pass");
        end else begin
            $display("chacha20_keystream_block_top regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cc20_pkg.sv
rtl/cc20_key_regs.sv
rtl/cc20_round_stage.sv
rtl/cc20_feedfwd.sv
rtl/chacha20_keystream_block_top.sv
test/chacha20_keystream_block_top_tb.sv
